// ===== rtl/core/mpm_pkg.sv =====
// Package: constants, types and states for the 2x2 modular matrix power block.
`timescale 1ns / 1ps
`default_nettype none
package mpm_pkg;
    localparam logic [31:0] MOD        = 32'd1000000007;
    localparam logic [63:0] BAR_M_FULL = 64'h2000_0000_0000_0000 / 64'd1000000007;
    localparam logic [31:0] BAR_M      = BAR_M_FULL[31:0];

    typedef logic [29:0] t_entry;
    typedef logic [62:0] t_exp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BIT,
        S_MUL0,
        S_MUL1,
        S_ADD,
        S_BQ,
        S_BQP,
        S_SUB,
        S_CORR,
        S_MEND,
        S_BITEND,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/core/mpm_if.sv =====
// Interfaces: input and output beat channels of the matrix power block.
`timescale 1ns / 1ps
`default_nettype none
interface mpm_in_if;
    import mpm_pkg::*;
    logic   valid;
    logic   ready;
    t_entry base_00;
    t_entry base_01;
    t_entry base_10;
    t_entry base_11;
    t_exp   exponent;
    modport source (output valid, base_00, base_01, base_10, base_11, exponent, input ready);
    modport sink   (input valid, base_00, base_01, base_10, base_11, exponent, output ready);
endinterface

interface mpm_out_if;
    import mpm_pkg::*;
    logic   valid;
    logic   ready;
    t_entry out_00;
    t_entry out_01;
    t_entry out_10;
    t_entry out_11;
    modport source (output valid, out_00, out_01, out_10, out_11, input ready);
    modport sink   (input valid, out_00, out_01, out_10, out_11, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/matrix_power_mod.sv =====
// Top level: 2x2 matrix power modulo 1000000007 on one shared 32x32 multiplier.
//
// Usage:
//   i_in  beat: four base entries and a 63-bit exponent.
//   o_out beat: base^exponent mod 1000000007, one beat per input beat.
//   One item at a time: i_in.ready is high only while idle.
//   Exponent bits are scanned from the top; leading zero bits and the first
//   set bit need no multiply, the first set bit loading the base. After
//   that, each bit takes a squaring and, for a set bit, a multiply by the
//   base. A matrix product computes four entries and then updates the
//   result; each entry takes two products, an add, a Barrett quotient and
//   product, a subtract and compare-subtract steps until the remainder is
//   below the modulus, all on the single multiplier.
//   The result beat is held on o_out until taken; a stalled receiver only
//   delays the return to idle.
//   Reset (i_rst_n low, synchronous) returns to idle and drops o_out.valid.
`timescale 1ns / 1ps
`default_nettype none
module matrix_power_mod (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mpm_in_if.sink     i_in,
    mpm_out_if.source  o_out
);
    import mpm_pkg::*;

    t_state r_state, n_state;
    t_entry r_a00, r_a01, r_a10, r_a11;
    t_entry r_b00, r_b01, r_b10, r_b11;
    t_entry r_c00, r_c01, r_c10, r_c11;
    t_exp   r_exp;
    logic [5:0]  r_bit;
    logic [1:0]  r_ent;
    logic        r_sq;
    logic        r_started;
    logic [59:0] r_p0, r_p1;
    logic [60:0] r_x;
    logic [63:0] r_t;
    logic [31:0] r_qp;
    logic [31:0] r_r;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_y;
    t_entry      op_a, op_b;
    logic        k;
    logic        cur_bit;
    logic        mod_ge;

    assign mul_y   = 64'(mul_a) * 64'(mul_b);
    assign cur_bit = r_exp[r_bit];
    assign mod_ge  = (r_r >= MOD);
    assign k       = (r_state == S_MUL1);

    function automatic t_entry red_in(input t_entry v);
        red_in = (32'(v) >= MOD) ? t_entry'(32'(v) - MOD) : v;
    endfunction

    always_comb begin
        unique case ({r_ent[1], k})
            2'd0: op_a = r_a00;
            2'd1: op_a = r_a01;
            2'd2: op_a = r_a10;
            default: op_a = r_a11;
        endcase
        unique case ({k, r_ent[0]})
            2'd0: op_b = r_sq ? r_a00 : r_b00;
            2'd1: op_b = r_sq ? r_a01 : r_b01;
            2'd2: op_b = r_sq ? r_a10 : r_b10;
            default: op_b = r_sq ? r_a11 : r_b11;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in.valid) n_state = S_BIT;
            S_BIT:    n_state = r_started ? S_MUL0 : S_BITEND;
            S_MUL0:   n_state = S_MUL1;
            S_MUL1:   n_state = S_ADD;
            S_ADD:    n_state = S_BQ;
            S_BQ:     n_state = S_BQP;
            S_BQP:    n_state = S_SUB;
            S_SUB:    n_state = S_CORR;
            S_CORR: begin
                if (!mod_ge) n_state = (r_ent == 2'd3) ? S_MEND : S_MUL0;
            end
            S_MEND:   n_state = (r_sq && cur_bit) ? S_MUL0 : S_BITEND;
            S_BITEND: n_state = (r_bit == 6'd0) ? S_OUT : S_BIT;
            S_OUT:    if (o_out.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs and multiplier operands
    always_comb begin
        i_in.ready  = (r_state == S_IDLE);
        o_out.valid = (r_state == S_OUT);
        mul_a = 32'(op_a);
        mul_b = 32'(op_b);
        unique case (r_state)
            S_BQ: begin
                mul_a = r_x[60:29];
                mul_b = BAR_M;
            end
            S_BQP: begin
                mul_a = r_t[63:32];
                mul_b = MOD;
            end
            default: ;
        endcase
    end

    assign o_out.out_00 = r_a00;
    assign o_out.out_01 = r_a01;
    assign o_out.out_10 = r_a10;
    assign o_out.out_11 = r_a11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    r_b00     <= red_in(i_in.base_00);
                    r_b01     <= red_in(i_in.base_01);
                    r_b10     <= red_in(i_in.base_10);
                    r_b11     <= red_in(i_in.base_11);
                    r_exp     <= i_in.exponent;
                    r_a00     <= t_entry'(1);
                    r_a01     <= '0;
                    r_a10     <= '0;
                    r_a11     <= t_entry'(1);
                    r_bit     <= 6'd62;
                    r_started <= 1'b0;
                end
            end
            S_BIT: begin
                r_ent <= 2'd0;
                r_sq  <= 1'b1;
                if (!r_started && cur_bit) begin
                    // first set bit: identity times base
                    r_started <= 1'b1;
                    r_a00 <= r_b00;
                    r_a01 <= r_b01;
                    r_a10 <= r_b10;
                    r_a11 <= r_b11;
                end
            end
            S_MUL0: r_p0 <= mul_y[59:0];
            S_MUL1: r_p1 <= mul_y[59:0];
            S_ADD:  r_x  <= 61'(r_p0) + 61'(r_p1);
            S_BQ:   r_t  <= mul_y;
            S_BQP:  r_qp <= mul_y[31:0];
            S_SUB:  r_r  <= r_x[31:0] - r_qp;
            S_CORR: begin
                if (mod_ge) begin
                    r_r <= r_r - MOD;
                end else begin
                    unique case (r_ent)
                        2'd0: r_c00 <= r_r[29:0];
                        2'd1: r_c01 <= r_r[29:0];
                        2'd2: r_c10 <= r_r[29:0];
                        default: r_c11 <= r_r[29:0];
                    endcase
                    r_ent <= r_ent + 2'd1;
                end
            end
            S_MEND: begin
                r_a00 <= r_c00;
                r_a01 <= r_c01;
                r_a10 <= r_c10;
                r_a11 <= r_c11;
                r_ent <= 2'd0;
                r_sq  <= 1'b0;
            end
            S_BITEND: r_bit <= r_bit - 6'd1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/mpm_checker.sv =====
// Checker: port-level properties of the matrix power block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mpm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [29:0] i_out_00
);
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while result pending");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> (!i_in_ready && !i_out_valid))
        else $error("not busy after input beat");

    a_idle_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |=> (i_in_ready && !i_out_valid))
        else $error("not idle after output beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_00)))
        else $error("stalled output beat changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("not idle after reset");
endmodule

bind matrix_power_mod mpm_checker u_mpm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_00    (o_out.out_00)
);
`default_nettype wire

// ===== verif/matrix_power_mod_test.sv =====
// Testbench: 2x2 matrix power mod prime, checked beat by beat against a behavioral model.
`timescale 1ns / 1ps
module matrix_power_mod_test;
    import mpm_pkg::*;

    localparam longint unsigned PRIME = 64'd1000000007;
    localparam int STALL_LIMIT = 50000;

    typedef struct {
        t_entry m00;
        t_entry m01;
        t_entry m10;
        t_entry m11;
    } t_mat;

    logic i_clk;
    logic i_rst_n;
    mpm_in_if  in_ch ();
    mpm_out_if out_ch ();

    matrix_power_mod uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_mat   expected_powers[$];
    int     errors = 0;
    int     idle_pct = 27;
    int     hold_cycles = 0;
    int     quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b);
        return (a * b) % PRIME;
    endfunction

    function automatic t_mat mat_product(t_mat a, t_mat b);
        t_mat r;
        r.m00 = t_entry'((mul_mod(a.m00, b.m00) + mul_mod(a.m01, b.m10)) % PRIME);
        r.m01 = t_entry'((mul_mod(a.m00, b.m01) + mul_mod(a.m01, b.m11)) % PRIME);
        r.m10 = t_entry'((mul_mod(a.m10, b.m00) + mul_mod(a.m11, b.m10)) % PRIME);
        r.m11 = t_entry'((mul_mod(a.m10, b.m01) + mul_mod(a.m11, b.m11)) % PRIME);
        return r;
    endfunction

    function automatic t_mat mat_power(t_mat base, t_exp e);
        t_mat b;
        t_mat acc;
        b.m00 = t_entry'(64'(base.m00) % PRIME);
        b.m01 = t_entry'(64'(base.m01) % PRIME);
        b.m10 = t_entry'(64'(base.m10) % PRIME);
        b.m11 = t_entry'(64'(base.m11) % PRIME);
        acc.m00 = 1; acc.m01 = 0; acc.m10 = 0; acc.m11 = 1;
        for (int i = 62; i >= 0; i--) begin
            acc = mat_product(acc, acc);
            if (e[i]) acc = mat_product(acc, b);
        end
        return acc;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.base_00 = '0; in_ch.base_01 = '0; in_ch.base_10 = '0; in_ch.base_11 = '0;
        in_ch.exponent = '0;
        out_ch.ready = 1'b0;
    end

    // sink side: random stalls plus a long hold-off window
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_mat e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_powers.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                e = expected_powers.pop_front();
                if (out_ch.out_00 !== e.m00)
                    report_mismatch($sformatf("out_00 %0d exp %0d", out_ch.out_00, e.m00));
                if (out_ch.out_01 !== e.m01)
                    report_mismatch($sformatf("out_01 %0d exp %0d", out_ch.out_01, e.m01));
                if (out_ch.out_10 !== e.m10)
                    report_mismatch($sformatf("out_10 %0d exp %0d", out_ch.out_10, e.m10));
                if (out_ch.out_11 !== e.m11)
                    report_mismatch($sformatf("out_11 %0d exp %0d", out_ch.out_11, e.m11));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // valid stays high from one beat to the next unless an idle cycle is drawn
    task automatic send_matrix(t_entry a, t_entry b, t_entry c, t_entry d, t_exp e);
        t_mat m;
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.base_00 <= a; in_ch.base_01 <= b; in_ch.base_10 <= c; in_ch.base_11 <= d;
        in_ch.exponent <= e;
        do @(posedge i_clk); while (!in_ch.ready);
        m.m00 = a; m.m01 = b; m.m10 = c; m.m11 = d;
        expected_powers.insert(expected_powers.size(), mat_power(m, e));
    endtask

    function automatic t_entry rand_entry();
        case ($urandom_range(5))
            0: return '0;
            1: return t_entry'(PRIME - 1);
            2: return t_entry'($urandom_range(1073741823, 1000000007));
            3: return t_entry'($urandom_range(9));
            default: return t_entry'($urandom_range(1000000006));
        endcase
    endfunction

    function automatic t_exp rand_exp();
        t_exp e;
        e = t_exp'({$urandom, $urandom});
        // mostly short exponents to keep the run bounded
        case ($urandom_range(9))
            0: return e;
            1, 2: return e >> $urandom_range(62, 32);
            default: return e >> $urandom_range(62, 48);
        endcase
    endfunction

    task automatic test_directed();
        t_entry mx = t_entry'(PRIME - 1);
        send_matrix(0, 0, 0, 0, 0);
        send_matrix(mx, mx, mx, mx, 0);
        send_matrix(0, 0, 0, 0, 1);
        send_matrix(1, 1, 1, 0, 10);
        send_matrix(1, 1, 1, 0, 90);
        send_matrix(mx, mx, mx, mx, 1);
        send_matrix(mx, mx, mx, mx, 2);
        send_matrix(mx, mx, mx, mx, '1);
        send_matrix('1, '1, '1, '1, 1);
        send_matrix('1, '1, '1, '1, 3);
        send_matrix(30'd1000000007, 30'd1000000008, 0, '1, 5);
        send_matrix(2, 3, 5, 7, 63'h4000_0000_0000_0000);
        send_matrix(2, 3, 5, 7, 63'h2AAA_AAAA_AAAA_AAAA);
        send_matrix(12345, 0, 0, 67890, 63'h5555_5555_5555_5555);
        send_matrix(1, 0, 0, 1, '1);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_matrix(rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_exp());
    endtask

    task automatic test_no_idle(int n);
        idle_pct = 0;
        test_random(n);
        idle_pct = 27;
    endtask

    task automatic test_backpressure(int n);
        hold_cycles = 3000;
        test_random(n);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_powers.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(250);
        test_no_idle(120);
        test_backpressure(6);
        test_random(150);
        drain();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
